@@ hw/rtl/qfts_pkg.sv @@
// Package: sizes, command and status types for the two-stack queue
`timescale 1ns / 1ps

package qfts_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [2:0] {
    RSP_PUSH,
    RSP_DROP,
    RSP_EMPTY,
    RSP_IN,
    RSP_OUT
  } rsp_sel_e;

  typedef struct packed {
    logic     load;
    logic     push_wr;
    logic     in_pop;
    logic     out_pop;
    logic     out_push;
    logic     rsp_valid;
    rsp_sel_e rsp_sel;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic in_full;
    logic in_empty;
    logic out_empty;
  } status_t;

endpackage

@@ hw/rtl/qfts_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module qfts_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/qfts_dpath.sv @@
// Datapath: stack RAMs, stack counts, latched item and result registers
`timescale 1ns / 1ps

module qfts_dpath import qfts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     was_empty_o,
  output logic                     push_dropped_o
);

  logic              is_pop_q;
  logic [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]  in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [CNT_W-1:0]  in_top, out_top;
  logic [DATA_W-1:0] in_rdata, out_rdata;
  logic              valid_q;
  logic [DATA_W-1:0] data_q, data_d;
  logic              empty_q, empty_d;
  logic              drop_q, drop_d;

  assign in_top  = in_cnt_q - CNT_W'(1);
  assign out_top = out_cnt_q - CNT_W'(1);

  qfts_ram #(.Width(DATA_W), .Depth(DEPTH)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr),
    .waddr_i (in_cnt_q[ADDR_W-1:0]),
    .wdata_i (value_q),
    .raddr_i (in_top[ADDR_W-1:0]),
    .rdata_o (in_rdata)
  );

  qfts_ram #(.Width(DATA_W), .Depth(DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.out_push),
    .waddr_i (out_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_rdata),
    .raddr_i (out_top[ADDR_W-1:0]),
    .rdata_o (out_rdata)
  );

  always_comb begin
    in_cnt_d = in_cnt_q;
    if (cmd_i.push_wr) begin
      in_cnt_d = in_cnt_q + CNT_W'(1);
    end else if (cmd_i.in_pop) begin
      in_cnt_d = in_top;
    end
    out_cnt_d = out_cnt_q;
    if (cmd_i.out_push) begin
      out_cnt_d = out_cnt_q + CNT_W'(1);
    end else if (cmd_i.out_pop) begin
      out_cnt_d = out_top;
    end
  end

  always_comb begin
    data_d  = '0;
    empty_d = 1'b0;
    drop_d  = 1'b0;
    case (cmd_i.rsp_sel)
      RSP_PUSH:  data_d  = '0;
      RSP_DROP:  drop_d  = 1'b1;
      RSP_EMPTY: empty_d = 1'b1;
      RSP_IN:    data_d  = in_rdata;
      RSP_OUT:   data_d  = out_rdata;
      default:   data_d  = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      valid_q   <= cmd_i.rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_pop_q <= func_i;
      value_q  <= value_i;
    end
    if (cmd_i.rsp_valid) begin
      data_q  <= data_d;
      empty_q <= empty_d;
      drop_q  <= drop_d;
    end
  end

  assign status_o.is_pop    = (is_pop_q == FUNC_POP);
  assign status_o.in_full   = (in_cnt_q == CNT_W'(DEPTH));
  assign status_o.in_empty  = (in_cnt_q == '0);
  assign status_o.out_empty = (out_cnt_q == '0);

  assign valid_o        = valid_q;
  assign data_out_o     = data_q;
  assign was_empty_o    = empty_q;
  assign push_dropped_o = drop_q;

`ifndef SYNTHESIS
  a_in_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q <= CNT_W'(DEPTH))
    else $error("in-stack count beyond depth");
  a_out_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= CNT_W'(DEPTH))
    else $error("out-stack count beyond depth");
  a_refill_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_push |-> !cmd_i.out_pop)
    else $error("out-stack pushed and popped together");
`endif

endmodule

@@ hw/rtl/qfts_ctrl.sv @@
// Controller: sequences push, pop and the in-stack to out-stack transfer
`timescale 1ns / 1ps

module qfts_ctrl import qfts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DECODE   = 2'd1;
  localparam logic [1:0] S_XFER     = 2'd2;
  localparam logic [1:0] S_POP_WAIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, rsp_sel: RSP_PUSH};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status_i.is_pop) begin
          cmd_o.rsp_valid = 1'b1;
          state_d         = S_IDLE;
          if (status_i.in_full) begin
            cmd_o.rsp_sel = RSP_DROP;
          end else begin
            cmd_o.push_wr = 1'b1;
            cmd_o.rsp_sel = RSP_PUSH;
          end
        end else if (!status_i.out_empty) begin
          cmd_o.out_pop = 1'b1;
          state_d       = S_POP_WAIT;
        end else if (status_i.in_empty) begin
          cmd_o.rsp_valid = 1'b1;
          cmd_o.rsp_sel   = RSP_EMPTY;
          state_d         = S_IDLE;
        end else begin
          cmd_o.in_pop = 1'b1;
          state_d      = S_XFER;
        end
      end
      S_XFER: begin
        if (status_i.in_empty) begin
          // hand the oldest entry straight out instead of stacking it
          cmd_o.rsp_valid = 1'b1;
          cmd_o.rsp_sel   = RSP_IN;
          state_d         = S_IDLE;
        end else begin
          cmd_o.out_push = 1'b1;
          cmd_o.in_pop   = 1'b1;
        end
      end
      S_POP_WAIT: begin
        cmd_o.rsp_valid = 1'b1;
        cmd_o.rsp_sel   = RSP_OUT;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but controller not busy");
  a_rsp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rsp_valid |=> !busy_o)
    else $error("result issued without return to idle");
  a_xfer_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_pop |-> status_i.is_pop && !status_i.in_empty)
    else $error("in-stack read outside a pop or when empty");
`endif

endmodule

@@ hw/rtl/queue_from_two_stacks_unit.sv @@
// Top level: first-in first-out queue of 32-bit words built from two stacks
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its single result shows
// on the result ports for one cycle with valid_o high and cannot be held off.
// A push, a refused push and a pop of an empty queue go through decode to the
// result; a pop served from the out-stack also passes pop-wait. A pop that finds
// the out-stack empty moves each in-stack entry but the oldest, one a cycle, into
// the out-stack and hands the oldest out. Busy is low in the cycle the result
// shows, so the next item can be taken then. No clearing pass after reset.
module queue_from_two_stacks_unit import qfts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     was_empty_o,
  output logic                     push_dropped_o
);

  cmd_t    cmd;
  status_t status;

  qfts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  qfts_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (func_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .valid_o        (valid_o),
    .data_out_o     (data_out_o),
    .was_empty_o    (was_empty_o),
    .push_dropped_o (push_dropped_o)
  );

`ifndef SYNTHESIS
  a_valid_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while still busy");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(was_empty_o && push_dropped_o))
    else $error("empty and dropped flags together");
  a_flag_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (was_empty_o || push_dropped_o)) |-> data_out_o == '0)
    else $error("flagged result carries data");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for the two-stack queue: predicted item-by-item checking under random idling
`timescale 1ns / 1ps

module tb_top;
  import qfts_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_ITEMS = 150;
  localparam int RANDOM_ITEMS = 900;

  typedef struct {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } q_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic                     empty;
    logic                     dropped;
  } q_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     func_i = FUNC_PUSH;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     valid_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic                     was_empty_o;
  logic                     push_dropped_o;

  q_item_t   pending_items[$];
  q_result_t expected_results[$];

  logic [DATA_W-1:0] in_stack[DEPTH];
  logic [DATA_W-1:0] out_stack[DEPTH];
  int unsigned       in_level;
  int unsigned       out_level;

  int unsigned n_push, n_pop, n_drop, n_empty, n_move, n_results;
  int unsigned n_errors;
  int unsigned idle_cycles;

  q_item_t     cur_item;
  int unsigned gap_left;
  int unsigned idle_pct;
  int unsigned since_redraw;

  queue_from_two_stacks_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .data_out_o    (data_out_o),
    .was_empty_o   (was_empty_o),
    .push_dropped_o(push_dropped_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic q_result_t queue_next_result(q_item_t it);
    q_result_t r;
    r.data = '0;
    r.empty = 1'b0;
    r.dropped = 1'b0;
    if (it.func == FUNC_PUSH) begin
      n_push++;
      if (in_level >= DEPTH) begin
        r.dropped = 1'b1;
        n_drop++;
      end else begin
        in_stack[in_level] = it.value;
        in_level++;
      end
    end else begin
      n_pop++;
      if (out_level == 0 && in_level > 0) begin
        n_move++;
        while (in_level > 0 && out_level < DEPTH) begin
          in_level--;
          out_stack[out_level] = in_stack[in_level];
          out_level++;
        end
      end
      if (out_level == 0) begin
        r.empty = 1'b1;
        n_empty++;
      end else begin
        out_level--;
        r.data = out_stack[out_level];
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic add_item(logic f, logic [DATA_W-1:0] v);
    q_item_t it;
    it.func = f;
    it.value = v;
    pending_items.push_back(it);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // drive items, predicting each one as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= FUNC_PUSH;
      value_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(queue_next_result(cur_item));
        since_redraw++;
        if (since_redraw >= 40) begin
          since_redraw = 0;
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
          endcase
        end
        if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 13);
      end
      if (start && busy) begin
        // hold the presented item
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        start <= 1'b1;
        func_i <= cur_item.func;
        value_i <= cur_item.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    q_result_t want;
    if (rst_ni && valid_o) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report("result with no item waiting", data_out_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (data_out_o !== want.data)
          report("data_out", data_out_o, want.data);
        if (was_empty_o !== want.empty)
          report("was_empty", was_empty_o, want.empty);
        if (push_dropped_o !== want.dropped)
          report("push_dropped", push_dropped_o, want.dropped);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned run_len;
    int unsigned push_pct;
    int unsigned n_random;
    in_level = 0;
    out_level = 0;
    gap_left = 0;
    idle_pct = 15;
    since_redraw = 0;
    idle_cycles = 0;
    n_random = 0;

    add_item(FUNC_POP, '0);
    add_item(FUNC_PUSH, 32'h7fff_ffff);
    add_item(FUNC_PUSH, 32'h8000_0000);
    add_item(FUNC_PUSH, 32'hffff_ffff);
    add_item(FUNC_PUSH, 32'h0000_0000);
    add_item(FUNC_POP, 32'hffff_ffff);
    add_item(FUNC_PUSH, 32'h0000_0001);
    add_item(FUNC_POP, '0);
    for (int i = 0; i < 7; i++)
      add_item(FUNC_PUSH, 32'h1111_1111 * (i + 2));
    add_item(FUNC_PUSH, 32'hdead_beef);
    add_item(FUNC_PUSH, 32'hffff_ffff);
    add_item(FUNC_POP, '0);
    add_item(FUNC_POP, '0);
    add_item(FUNC_POP, '0);
    add_item(FUNC_PUSH, 32'h5555_5555);
    add_item(FUNC_PUSH, 32'haaaa_aaaa);
    add_item(FUNC_POP, '0);
    add_item(FUNC_POP, '0);

    // bursts with a drifting push bias, so the queue swings between full and empty
    while (n_random < RANDOM_ITEMS) begin
      run_len = $urandom_range(1, 24);
      case ($urandom_range(0, 4))
        0: push_pct = 10;
        1: push_pct = 30;
        2: push_pct = 50;
        3: push_pct = 70;
        default: push_pct = 90;
      endcase
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          add_item(FUNC_PUSH, pick_value());
        else
          add_item(FUNC_POP, $urandom);
        n_random++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d pushes (%0d dropped) and %0d pops (%0d empty, %0d stack moves)",
             n_push, n_drop, n_pop, n_empty, n_move);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/qfts_pkg.sv
hw/rtl/qfts_ram.sv
hw/rtl/qfts_dpath.sv
hw/rtl/qfts_ctrl.sv
hw/rtl/queue_from_two_stacks_unit.sv
sim/tb_top.sv
